// ----- sv/env_kvs_pkg.sv -----
`timescale 1ns / 1ps

package env_kvs_pkg;

	localparam int KEY_W    = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEARCH_MODE = 2'd0,
		CFG_SEARCH_KEY  = 2'd1,
		CFG_KEY_LENGTH  = 2'd2
	} cfg_idx_t;

	// scan state carried from byte to byte
	typedef struct packed {
		logic [2:0] header_left;
		logic       printing_on;
		logic       still_matching;
		logic       at_entry_start;
		logic [3:0] match_position;
		logic       finished;
	} scan_state_t;

	// configuration registers as seen by the step logic
	typedef struct packed {
		logic             search_mode;
		logic [KEY_W-1:0] search_key;
		logic [3:0]       key_length;
	} scan_cfg_t;

	// one result of a step
	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [7:0] out_char;
		logic       exit_status;
	} scan_result_t;

endpackage

// ----- sv/env_kvs_step.sv -----
`timescale 1ns / 1ps

module env_kvs_step #(
	parameter int MAX_KEY_BYTES = 8
) (
	input  env_kvs_pkg::scan_state_t  cur,
	input  env_kvs_pkg::scan_cfg_t    cfg,
	input  logic [7:0]                ch,
	input  logic                      eoi,
	output env_kvs_pkg::scan_state_t  nxt,
	output env_kvs_pkg::scan_result_t res
);
	import env_kvs_pkg::*;

	logic [3:0] klen;
	logic [7:0] key_byte;

	// key length clamped to what the key register can hold
	assign klen = (cfg.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : cfg.key_length;
	assign key_byte = cfg.search_key[{cur.match_position[2:0], 3'b000} +: 8];

	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.finished) begin
			// input ignored until reset
		end else if (eoi) begin
			nxt.finished    = 1'b1;
			res.emit        = 1'b1;
			res.kind        = KIND_FINISH;
			res.exit_status = cur.printing_on ? STATUS_OK : STATUS_NOT_FOUND;
		end else if (cur.header_left != 3'd0) begin
			nxt.header_left = cur.header_left - 3'd1;
		end else if (ch == CH_NUL) begin
			if (cfg.search_mode && cur.printing_on) begin
				nxt.finished    = 1'b1;
				res.emit        = 1'b1;
				res.kind        = KIND_FINISH;
				res.exit_status = STATUS_OK;
			end else if (cur.at_entry_start) begin
				// empty entry ends the image
				nxt.finished    = 1'b1;
				res.emit        = 1'b1;
				res.kind        = KIND_FINISH;
				res.exit_status = cur.printing_on ? STATUS_OK : STATUS_NOT_FOUND;
			end else begin
				nxt.at_entry_start = 1'b1;
				nxt.still_matching = cfg.search_mode;
				nxt.match_position = 4'd0;
				res.emit           = cur.printing_on;
				res.kind           = KIND_CHAR;
				res.out_char       = CH_NEWLINE;
			end
		end else begin
			nxt.at_entry_start = 1'b0;
			if (cur.still_matching) begin
				if (cur.match_position >= klen) begin
					nxt.printing_on    = (ch == CH_EQUALS);
					nxt.still_matching = 1'b0;
				end else begin
					nxt.still_matching = (ch == key_byte);
					nxt.match_position = cur.match_position + 4'd1;
				end
			end
			res.emit     = cur.printing_on;
			res.kind     = KIND_CHAR;
			res.out_char = ch;
		end
	end

endmodule

// ----- sv/env_block_key_value_scanner_unit.sv -----
`timescale 1ns / 1ps

// environment image key/value scanner: takes one image byte per item and, after
// dropping the checksum header, either dumps every entry (nul shown as newline)
// or prints the value of the entry whose key matches the configured key; a
// finish item with exit status closes the scan, and later input is swallowed
// until reset. one input item is accepted every cycle unless the output register
// stalls; a result is registered: the byte sits in the input register, and the
// combinational step logic loads the output register from it when the stage
// advances. the output register stalls the input side only when it is full and
// not being taken. configuration is written through its own always-ready
// channel; the user must write it only while the block is idle, which the block
// itself does not enforce; writing search_mode reloads the match and print flags.

module env_block_key_value_scanner_unit #(
	parameter int MAX_KEY_BYTES = 8,
	parameter int HEADER_BYTES  = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte stream in
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic                               end_of_input,
	// results out
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               kind,
	output logic [7:0]                         out_char,
	output logic                               exit_status,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [env_kvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [env_kvs_pkg::KEY_W-1:0]      cfg_data
);
	import env_kvs_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eoi_s1;

	// scan state and configuration
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_cfg_t    cfg_q;
	scan_result_t res;

	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  out_char_q;
	logic        exit_status_q;

	logic advance;
	logic cfg_wr;

	// the stage moves when the output register is free or being emptied
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	env_kvs_step #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.ch  (data_s1),
		.eoi (eoi_s1),
		.nxt (state_nxt),
		.res (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// scan state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                  <= '0;
			state_q.header_left    <= 3'(HEADER_BYTES);
			state_q.printing_on    <= 1'b1;
			state_q.still_matching <= 1'b0;
			state_q.at_entry_start <= 1'b1;
			state_q.match_position <= 4'd0;
			state_q.finished       <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
			if (cfg_wr) begin
				case (cfg_index)
					CFG_SEARCH_MODE: begin
						cfg_q.search_mode      <= cfg_data[0];
						state_q.printing_on    <= !cfg_data[0];
						state_q.still_matching <= cfg_data[0];
						state_q.match_position <= 4'd0;
					end
					CFG_SEARCH_KEY: begin
						cfg_q.search_key <= cfg_data;
					end
					CFG_KEY_LENGTH: begin
						cfg_q.key_length <= cfg_data[3:0];
					end
					default: begin
						// unused index, write dropped
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.emit) begin
			kind_q        <= res.kind;
			out_char_q    <= res.out_char;
			exit_status_q <= res.exit_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_char    = out_char_q;
	assign exit_status = exit_status_q;

endmodule
